// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the wavelength estimator.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define PWE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every rising edge, also during reset.
`define PWE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/pwe_pkg.sv -----
// Shared types and constants of the profile wavelength estimator.
// No dependencies; used by pwe_div, pwe_track and the top level.
package pwe_pkg;

    localparam int X_W       = 32;
    localparam int DEN_W     = 32;
    localparam int QUO_W     = 34;
    localparam int DVD_W     = DEN_W + QUO_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int PEAK_W    = 8;
    localparam int CROSS_W   = 9;
    localparam int WL_W      = 31;
    localparam int METH_W    = 2;
    localparam int REG_IDX_W = 2;

    localparam logic [METH_W-1:0] METHOD_NONE    = 2'd0;
    localparam logic [METH_W-1:0] METHOD_SPACING = 2'd1;
    localparam logic [METH_W-1:0] METHOD_PEAKS   = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MEAN      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DOMAIN    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_VALID     = 2'd3;

    localparam logic [X_W-1:0]  MEAN_RESET      = 32'd0;
    localparam logic [WL_W-1:0] THRESHOLD_RESET = 31'd328;
    localparam logic [WL_W-1:0] DOMAIN_RESET    = 31'd65536;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic take;
        logic cross_wr;
        logic clear;
    } trk_ctrl_t;

    typedef struct packed {
        logic               crossing;
        logic               dx_neg;
        logic [DEN_W-1:0]   mag_y1;
        logic [DEN_W-1:0]   mag_dx;
        logic [DEN_W-1:0]   den;
        logic [X_W-1:0]     prev_x;
        logic               full;
        logic               ge4;
        logic [PEAK_W-1:0]  peaks;
        logic [CROSS_W-1:0] crossings;
        logic [DEN_W-1:0]   span;
        logic               span_pos;
    } trk_stat_t;

endpackage

// ----- rtl/profile_wavelength_estimator_top.sv -----
// Profile wavelength estimator, top level: APB registers, sequencer, output register;
// depends on pwe_pkg, pwe_track, pwe_div and assert_macros.svh. Samples (x, y) stream in
// and on the sample marked tlast one result leaves with the wavelength, the peak and
// crossing counts and the method used. A sample with a mean-level crossing passes through
// the multiply state for the 32x32 product of the interpolation and then a run of the
// one-bit-per-cycle divider, plus load and write-back. The last sample adds up to two
// more divider runs for the final wavelength, plus a state that chooses the method and a
// state that hands the result to the output register, where it waits while an earlier
// result is still held.
`include "assert_macros.svh"

module profile_wavelength_estimator_top #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_axis_tdata: sample_x [31:0], sample_y [63:32]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // m_axis_tdata: wavelength [30:0], peak_count [38:31], crossing_count [47:39]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    // m_axis_tuser: method_used [1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_XDIV   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_W1DIV  = 3'd4;
    localparam logic [2:0] ST_W2DIV  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [pwe_pkg::X_W-1:0]  mean_reg;
    logic [pwe_pkg::WL_W-1:0] thr_reg;
    logic [pwe_pkg::WL_W-1:0] dom_reg;
    logic                     valid_reg;

    logic [pwe_pkg::DEN_W-1:0] a_reg;
    logic [pwe_pkg::DEN_W-1:0] b_reg;
    logic [pwe_pkg::DEN_W-1:0] den_reg;
    logic                      neg_reg;
    logic [pwe_pkg::X_W-1:0]   base_x_reg;
    logic                      last_reg;

    logic [pwe_pkg::WL_W-1:0]   res_wl_reg;
    logic [pwe_pkg::METH_W-1:0] res_meth_reg;

    logic                        m_valid_reg;
    logic [pwe_pkg::WL_W-1:0]    m_wl_reg;
    logic [pwe_pkg::PEAK_W-1:0]  m_peaks_reg;
    logic [pwe_pkg::CROSS_W-1:0] m_cross_reg;
    logic [pwe_pkg::METH_W-1:0]  m_meth_reg;

    pwe_pkg::trk_ctrl_t trk_ctrl;
    pwe_pkg::trk_stat_t trk_stat;
    pwe_pkg::div_stat_t div_stat;

    logic                      div_start;
    logic [pwe_pkg::DVD_W-1:0] div_dvd;
    logic [pwe_pkg::DEN_W-1:0] div_den;
    logic [pwe_pkg::QUO_W-1:0] div_quo;

    logic [2*pwe_pkg::DEN_W-1:0] prod;
    logic [pwe_pkg::X_W-1:0]     cross_x;
    logic [pwe_pkg::WL_W-1:0]    w1_sat;
    logic                        s_take;
    logic                        take_ok;
    logic                        cfg_wr;
    logic                        out_free;
    logic                        use_spacing;
    logic                        out_stall;
    logic                        spacing_bad;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg  <= pwe_pkg::MEAN_RESET;
            thr_reg   <= pwe_pkg::THRESHOLD_RESET;
            dom_reg   <= pwe_pkg::DOMAIN_RESET;
            valid_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pwe_pkg::REG_MEAN:      mean_reg  <= pwdata;
                pwe_pkg::REG_THRESHOLD: thr_reg   <= pwdata[pwe_pkg::WL_W-1:0];
                pwe_pkg::REG_DOMAIN:    dom_reg   <= pwdata[pwe_pkg::WL_W-1:0];
                pwe_pkg::REG_VALID:     valid_reg <= pwdata[0];
                default:                mean_reg  <= mean_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pwe_pkg::REG_MEAN:      prdata = mean_reg;
            pwe_pkg::REG_THRESHOLD: prdata = {1'b0, thr_reg};
            pwe_pkg::REG_DOMAIN:    prdata = {1'b0, dom_reg};
            pwe_pkg::REG_VALID:     prdata = {31'd0, valid_reg};
            default:                prdata = '0;
        endcase
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign take_ok       = s_take && !trk_stat.full;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign use_spacing = trk_stat.ge4 && (trk_stat.crossings >= pwe_pkg::CROSS_W'(2))
                       && (trk_stat.peaks != '0) && trk_stat.span_pos;

    assign prod    = a_reg * b_reg;
    assign cross_x = neg_reg ? (base_x_reg - div_quo[pwe_pkg::X_W-1:0])
                             : (base_x_reg + div_quo[pwe_pkg::X_W-1:0]);
    assign w1_sat  = (div_quo[pwe_pkg::QUO_W-1:pwe_pkg::WL_W] != '0) ? '1
                                                                      : div_quo[pwe_pkg::WL_W-1:0];

    always_comb begin
        div_start = 1'b0;
        div_dvd   = {{(pwe_pkg::DVD_W - pwe_pkg::WL_W){1'b0}}, dom_reg};
        div_den   = {{(pwe_pkg::DEN_W - pwe_pkg::PEAK_W){1'b0}}, trk_stat.peaks};
        case (state_reg)
            ST_MUL: begin
                div_start = 1'b1;
                div_dvd   = {{(pwe_pkg::DVD_W - 2*pwe_pkg::DEN_W){1'b0}}, prod};
                div_den   = den_reg;
            end
            ST_FINISH: begin
                if (valid_reg && use_spacing) begin
                    div_start = 1'b1;
                    div_dvd   = {{(pwe_pkg::DVD_W - pwe_pkg::DEN_W - 1){1'b0}},
                                 trk_stat.span, 1'b0};
                    div_den   = {{(pwe_pkg::DEN_W - pwe_pkg::CROSS_W){1'b0}},
                                 trk_stat.crossings - pwe_pkg::CROSS_W'(1)};
                end else if (valid_reg && (trk_stat.peaks != '0)) begin
                    div_start = 1'b1;
                end
            end
            ST_W1DIV: begin
                if (div_stat.done && (w1_sat == '0)) begin
                    div_start = 1'b1;
                end
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        trk_ctrl.take     = take_ok;
        trk_ctrl.cross_wr = (state_reg == ST_XDIV) && div_stat.done;
        trk_ctrl.clear    = (state_reg == ST_OUT) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_ok && trk_stat.crossing) begin
                    state_next = ST_MUL;
                end else if (s_take && s_axis_tlast) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL: begin
                state_next = ST_XDIV;
            end
            ST_XDIV: begin
                if (div_stat.done) begin
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!valid_reg) begin
                    state_next = ST_OUT;
                end else if (use_spacing) begin
                    state_next = ST_W1DIV;
                end else if (trk_stat.peaks != '0) begin
                    state_next = ST_W2DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_W1DIV: begin
                if (div_stat.done) begin
                    state_next = (w1_sat == '0) ? ST_W2DIV : ST_OUT;
                end
            end
            ST_W2DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && take_ok && trk_stat.crossing) begin
            a_reg      <= trk_stat.mag_y1;
            b_reg      <= trk_stat.mag_dx;
            den_reg    <= trk_stat.den;
            neg_reg    <= trk_stat.dx_neg;
            base_x_reg <= trk_stat.prev_x;
            last_reg   <= s_axis_tlast;
        end
        case (state_reg)
            ST_FINISH: begin
                res_wl_reg   <= '0;
                res_meth_reg <= pwe_pkg::METHOD_NONE;
            end
            ST_W1DIV: begin
                if (div_stat.done && (w1_sat != '0)) begin
                    res_wl_reg   <= w1_sat;
                    res_meth_reg <= pwe_pkg::METHOD_SPACING;
                end
            end
            ST_W2DIV: begin
                if (div_stat.done && (div_quo[pwe_pkg::WL_W-1:0] != '0)) begin
                    res_wl_reg   <= div_quo[pwe_pkg::WL_W-1:0];
                    res_meth_reg <= pwe_pkg::METHOD_PEAKS;
                end
            end
            default: begin
                res_wl_reg <= res_wl_reg;
            end
        endcase
        if ((state_reg == ST_OUT) && out_free) begin
            m_wl_reg    <= res_wl_reg;
            m_meth_reg  <= res_meth_reg;
            m_peaks_reg <= valid_reg ? trk_stat.peaks : '0;
            m_cross_reg <= valid_reg ? trk_stat.crossings : '0;
        end
    end

    pwe_track #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (trk_ctrl),
        .sample_x       (s_axis_tdata[31:0]),
        .sample_y       (s_axis_tdata[63:32]),
        .mean_level     (mean_reg),
        .peak_threshold (thr_reg),
        .cross_x        (cross_x),
        .stat           (trk_stat)
    );

    pwe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_cross_reg, m_peaks_reg, m_wl_reg};
    assign m_axis_tuser  = m_meth_reg;

    assign out_stall   = (state_reg == ST_OUT) && m_valid_reg && !m_axis_tready;
    assign spacing_bad = m_valid_reg && (m_meth_reg == pwe_pkg::METHOD_SPACING)
                       && (m_cross_reg < pwe_pkg::CROSS_W'(2));

    `PWE_ASSERT(a_start_idle, aclk, aresetn, div_start |-> !div_stat.busy, "divider restarted")
    `PWE_ASSERT(a_out_wait, aclk, aresetn, out_stall |=> state_reg == ST_OUT, "result lost")
    `PWE_ASSERT(a_spacing_cross, aclk, aresetn, !spacing_bad, "spacing with few crossings")

endmodule

// ----- rtl/pwe_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle over a shift register.
// Depends on pwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pwe_pkg::DVD_W-1:0]  dividend,
    input  logic [pwe_pkg::DEN_W-1:0]  divisor,
    output pwe_pkg::div_stat_t         stat,
    output logic [pwe_pkg::QUO_W-1:0]  quotient
);

    logic [pwe_pkg::DEN_W-1:0]     rem_reg;
    logic [pwe_pkg::DEN_W-1:0]     den_reg;
    logic [pwe_pkg::QUO_W-1:0]     dvd_reg;
    logic [pwe_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [pwe_pkg::DEN_W:0]   trial;
    logic [pwe_pkg::DEN_W:0]   diff;
    logic                      fits;
    logic [pwe_pkg::DEN_W-1:0] rem_next;
    logic                      last_step;

    assign trial     = {rem_reg, dvd_reg[pwe_pkg::QUO_W-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};
    assign rem_next  = fits ? diff[pwe_pkg::DEN_W-1:0] : trial[pwe_pkg::DEN_W-1:0];
    assign last_step = cnt_reg == pwe_pkg::DIV_CNT_W'(pwe_pkg::DIV_STEPS - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + pwe_pkg::DIV_CNT_W'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[pwe_pkg::DVD_W-1 -: pwe_pkg::DEN_W];
            dvd_reg <= dividend[pwe_pkg::QUO_W-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[pwe_pkg::QUO_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

    `PWE_ASSERT(a_div_start_busy, aclk, aresetn, start |=> busy_reg, "divider did not start")
    `PWE_ASSERT_ALWAYS(a_div_done_pulse, aclk, done_reg |=> !done_reg, "done held longer than one cycle")

endmodule

// ----- rtl/pwe_track.sv -----
// Profile state: previous samples, peak and crossing counters, crossing positions.
// Classifies each incoming sample. Depends on pwe_pkg.
module pwe_track #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pwe_pkg::trk_ctrl_t        ctrl,
    input  logic [pwe_pkg::X_W-1:0]   sample_x,
    input  logic [pwe_pkg::X_W-1:0]   sample_y,
    input  logic [pwe_pkg::X_W-1:0]   mean_level,
    input  logic [pwe_pkg::WL_W-1:0]  peak_threshold,
    input  logic [pwe_pkg::X_W-1:0]   cross_x,
    output pwe_pkg::trk_stat_t        stat
);

    localparam int SAMP_W = $clog2(MAX_SAMPLES + 1);

    function automatic logic [pwe_pkg::DEN_W-1:0] mag33(input logic [pwe_pkg::DEN_W:0] v);
        logic [pwe_pkg::DEN_W:0] n;
        n = v[pwe_pkg::DEN_W] ? (~v + 33'd1) : v;
        return n[pwe_pkg::DEN_W-1:0];
    endfunction

    logic [pwe_pkg::X_W-1:0]     prev_y_reg;
    logic [pwe_pkg::X_W-1:0]     older_y_reg;
    logic [pwe_pkg::X_W-1:0]     prev_x_reg;
    logic [SAMP_W-1:0]           samples_reg;
    logic [pwe_pkg::PEAK_W-1:0]  peaks_reg;
    logic [pwe_pkg::CROSS_W-1:0] cross_reg;
    logic [pwe_pkg::X_W-1:0]     first_x_reg;
    logic [pwe_pkg::X_W-1:0]     last_x_reg;

    logic signed [pwe_pkg::X_W:0]   y1;
    logic signed [pwe_pkg::X_W:0]   y2;
    logic signed [pwe_pkg::X_W:0]   dx;
    logic signed [pwe_pkg::X_W:0]   dy;
    logic signed [pwe_pkg::X_W:0]   span;
    logic signed [pwe_pkg::X_W+1:0] level;
    logic signed [pwe_pkg::X_W+1:0] prev_ext;
    logic                           is_peak;
    logic                           is_cross;

    assign y1   = $signed({prev_y_reg[31], prev_y_reg}) - $signed({mean_level[31], mean_level});
    assign y2   = $signed({sample_y[31], sample_y}) - $signed({mean_level[31], mean_level});
    assign dx   = $signed({sample_x[31], sample_x}) - $signed({prev_x_reg[31], prev_x_reg});
    assign dy   = $signed({sample_y[31], sample_y}) - $signed({prev_y_reg[31], prev_y_reg});
    assign span = $signed({last_x_reg[31], last_x_reg}) - $signed({first_x_reg[31], first_x_reg});

    assign level    = $signed({mean_level[31], mean_level[31], mean_level})
                    + $signed({3'b000, peak_threshold});
    assign prev_ext = $signed({prev_y_reg[31], prev_y_reg[31], prev_y_reg});

    assign is_peak = (samples_reg >= SAMP_W'(2))
                   && ($signed(prev_y_reg) > $signed(older_y_reg))
                   && ($signed(prev_y_reg) > $signed(sample_y))
                   && (prev_ext > level);

    assign is_cross = (samples_reg != '0)
                    && (((y1 < 0) && (y2 > 0)) || ((y1 > 0) && (y2 < 0)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_y_reg  <= '0;
            older_y_reg <= '0;
            prev_x_reg  <= '0;
            samples_reg <= '0;
            peaks_reg   <= '0;
            cross_reg   <= '0;
            first_x_reg <= '0;
            last_x_reg  <= '0;
        end else if (ctrl.clear) begin
            prev_y_reg  <= '0;
            older_y_reg <= '0;
            prev_x_reg  <= '0;
            samples_reg <= '0;
            peaks_reg   <= '0;
            cross_reg   <= '0;
            first_x_reg <= '0;
            last_x_reg  <= '0;
        end else begin
            if (ctrl.take) begin
                older_y_reg <= prev_y_reg;
                prev_y_reg  <= sample_y;
                prev_x_reg  <= sample_x;
                samples_reg <= samples_reg + SAMP_W'(1);
                if (is_peak && (peaks_reg != '1)) begin
                    peaks_reg <= peaks_reg + pwe_pkg::PEAK_W'(1);
                end
            end
            if (ctrl.cross_wr) begin
                if (cross_reg == '0) begin
                    first_x_reg <= cross_x;
                end
                last_x_reg <= cross_x;
                if (cross_reg != '1) begin
                    cross_reg <= cross_reg + pwe_pkg::CROSS_W'(1);
                end
            end
        end
    end

    assign stat.crossing  = is_cross;
    assign stat.dx_neg    = dx[pwe_pkg::X_W];
    assign stat.mag_y1    = mag33(y1);
    assign stat.mag_dx    = mag33(dx);
    assign stat.den       = mag33(dy);
    assign stat.prev_x    = prev_x_reg;
    assign stat.full      = samples_reg == SAMP_W'(MAX_SAMPLES);
    assign stat.ge4       = samples_reg >= SAMP_W'(4);
    assign stat.peaks     = peaks_reg;
    assign stat.crossings = cross_reg;
    assign stat.span      = span[pwe_pkg::DEN_W-1:0];
    assign stat.span_pos  = !span[pwe_pkg::X_W] && (span != '0);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for profile_wavelength_estimator_top: drives profiles of (x, y)
// samples over the stream input, writes the APB registers between phases and compares
// every result against an internal model of the estimator. Depends on pwe_pkg and the RTL.
module tb;

    localparam int     MAX_SAMPLES   = 256;
    localparam int     CLK_HALF      = 4;
    localparam int     SETTLE_CYCLES = 150;
    localparam int     QUIET_LIMIT   = 20000;
    localparam longint INT32_MAX     = 64'sd2147483647;
    localparam longint INT32_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [pwe_pkg::WL_W-1:0]    wavelength;
        logic [pwe_pkg::PEAK_W-1:0]  peaks;
        logic [pwe_pkg::CROSS_W-1:0] crossings;
        logic [pwe_pkg::METH_W-1:0]  method;
    } wl_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int quiet_cycles = 0;

    wl_result_t expected_results[$];

    longint          est_mean;
    longint unsigned est_threshold;
    longint unsigned est_domain;
    bit              est_valid;

    longint prof_prev_y;
    longint prof_older_y;
    longint prof_prev_x;
    longint prof_first_xc;
    longint prof_last_xc;
    int     prof_samples;
    int     prof_peaks;
    int     prof_crossings;

    profile_wavelength_estimator_top #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic logic [31:0] clamp32(input longint v);
        if (v > INT32_MAX) return 32'h7fff_ffff;
        if (v < INT32_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    task automatic clear_profile();
        prof_prev_y = 0;
        prof_older_y = 0;
        prof_prev_x = 0;
        prof_first_xc = 0;
        prof_last_xc = 0;
        prof_samples = 0;
        prof_peaks = 0;
        prof_crossings = 0;
    endtask

    task automatic predict_sample(input logic [31:0] xin, input logic [31:0] yin,
                                  input bit last);
        longint          x;
        longint          y;
        longint          y1;
        longint          y2;
        longint          dx;
        longint          q;
        longint          xc;
        longint          span;
        longint unsigned mag_y1;
        longint unsigned mag_dx;
        longint unsigned den;
        longint unsigned w;
        wl_result_t      r;
        x = longint'($signed(xin));
        y = longint'($signed(yin));
        if (prof_samples < MAX_SAMPLES) begin
            if (prof_samples >= 2 && prof_prev_y > prof_older_y && prof_prev_y > y &&
                prof_prev_y > est_mean + longint'(est_threshold)) begin
                if (prof_peaks < 255) prof_peaks++;
            end
            if (prof_samples >= 1) begin
                y1 = prof_prev_y - est_mean;
                y2 = y - est_mean;
                if ((y1 < 0 && y2 > 0) || (y1 > 0 && y2 < 0)) begin
                    dx = x - prof_prev_x;
                    mag_y1 = (y1 < 0) ? -y1 : y1;
                    mag_dx = (dx < 0) ? -dx : dx;
                    den = (y2 - y1 < 0) ? -(y2 - y1) : (y2 - y1);
                    q = longint'((mag_y1 * mag_dx) / den);
                    xc = (dx < 0) ? prof_prev_x - q : prof_prev_x + q;
                    if (prof_crossings == 0) prof_first_xc = xc;
                    prof_last_xc = xc;
                    if (prof_crossings < 511) prof_crossings++;
                end
            end
            prof_older_y = prof_prev_y;
            prof_prev_y = y;
            prof_prev_x = x;
            prof_samples++;
        end
        if (!last) return;
        r = '0;
        r.method = pwe_pkg::METHOD_NONE;
        if (est_valid) begin
            span = prof_last_xc - prof_first_xc;
            if (prof_samples >= 4 && prof_crossings >= 2 && prof_peaks >= 1 && span > 0) begin
                w = (longint'(span) * 2) / longint'(prof_crossings - 1);
                if (w > 64'h7fff_ffff) w = 64'h7fff_ffff;
                if (w > 0) begin
                    r.wavelength = w[pwe_pkg::WL_W-1:0];
                    r.method = pwe_pkg::METHOD_SPACING;
                end
            end
            if (r.method == pwe_pkg::METHOD_NONE && prof_peaks >= 1) begin
                w = est_domain / longint'(prof_peaks);
                if (w > 0) begin
                    r.wavelength = w[pwe_pkg::WL_W-1:0];
                    r.method = pwe_pkg::METHOD_PEAKS;
                end
            end
            r.peaks = prof_peaks[pwe_pkg::PEAK_W-1:0];
            r.crossings = prof_crossings[pwe_pkg::CROSS_W-1:0];
        end
        expected_results.insert(expected_results.size(), r);
        clear_profile();
    endtask

    task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        s_axis_tlast <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_sample(x, y, last);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [pwe_pkg::REG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pwe_pkg::REG_MEAN:      est_mean = longint'($signed(value));
            pwe_pkg::REG_THRESHOLD: est_threshold = 64'(value[30:0]);
            pwe_pkg::REG_DOMAIN:    est_domain = 64'(value[30:0]);
            pwe_pkg::REG_VALID:     est_valid = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] mean, input logic [30:0] threshold,
                                input logic [30:0] domain, input bit valid);
        logic [31:0] junk;
        junk = $urandom;
        write_register(pwe_pkg::REG_MEAN, mean);
        write_register(pwe_pkg::REG_THRESHOLD, {junk[31], threshold});
        write_register(pwe_pkg::REG_DOMAIN, {junk[30], domain});
        write_register(pwe_pkg::REG_VALID, {junk[31:1], valid});
    endtask

    task automatic send_wave_profile(input int len, input bit reversed);
        longint x;
        longint dx_step;
        longint amp;
        longint lvl;
        longint jitter;
        longint yv;
        int     half;
        int     pos;
        int     cyc;
        amp = 1 + longint'($urandom >> $urandom_range(1, 31));
        half = $urandom_range(1, 6);
        pos = $urandom_range(0, 2 * half - 1);
        x = longint'($signed($urandom)) >>> $urandom_range(4, 12);
        dx_step = 1 + longint'($urandom_range(0, (1 << $urandom_range(1, 20)) - 1));
        if (reversed) dx_step = -dx_step;
        for (int i = 0; i < len; i++) begin
            cyc = (pos + i) % (2 * half);
            lvl = (cyc < half) ? cyc : 2 * half - cyc;
            yv = est_mean - amp + (2 * amp * lvl) / half;
            jitter = longint'($urandom) % (amp / 8 + 1);
            yv = $urandom_range(0, 1) ? yv + jitter : yv - jitter;
            send_sample(clamp32(x), clamp32(yv), i == len - 1);
            x = x + dx_step;
        end
    endtask

    task automatic send_noise_profile(input int len);
        for (int i = 0; i < len; i++) begin
            send_sample($urandom, $urandom, i == len - 1);
        end
    endtask

    task automatic apply_reset();
        est_mean = longint'($signed(pwe_pkg::MEAN_RESET));
        est_threshold = 64'(pwe_pkg::THRESHOLD_RESET);
        est_domain = 64'(pwe_pkg::DOMAIN_RESET);
        est_valid = 1'b1;
        clear_profile();
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
    endtask

    task automatic test_crossing_spacing();
        send_sample(32'd0, -32'sd65536, 1'b0);
        send_sample(32'd65536, 32'd65536, 1'b0);
        send_sample(32'd131072, -32'sd65536, 1'b0);
        send_sample(32'd196608, 32'd65536, 1'b1);
    endtask

    task automatic test_descending_x();
        send_sample(32'd300000, -32'sd65536, 1'b0);
        send_sample(32'd200000, 32'd65536, 1'b0);
        send_sample(32'd100000, -32'sd65536, 1'b0);
        send_sample(32'd0, 32'd65536, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        send_sample(32'h8000_0000, -32'sd65536, 1'b0);
        send_sample(32'h8000_0002, 32'd65536, 1'b0);
        send_sample(32'h7fff_fffd, 32'd131072, 1'b0);
        send_sample(32'h7fff_ffff, -32'sd65536, 1'b1);
    endtask

    task automatic test_invalid_profile();
        wait_idle();
        apply_config(32'd0, 31'd328, 31'd65536, 1'b0);
        test_crossing_spacing();
    endtask

    task automatic test_config_extremes();
        wait_idle();
        apply_config(32'd0, 31'h7fff_ffff, 31'd65536, 1'b1);
        send_sample(32'd0, 32'd0, 1'b0);
        send_sample(32'd1, 32'h7fff_ffff, 1'b0);
        send_sample(32'd2, 32'd0, 1'b1);
        wait_idle();
        apply_config(32'h7fff_ffff, 31'd0, 31'd0, 1'b1);
        send_sample(32'd0, -32'sd5, 1'b0);
        send_sample(32'd1, 32'h7fff_ffff, 1'b0);
        send_sample(32'd2, -32'sd5, 1'b1);
        wait_idle();
        apply_config(32'h8000_0000, 31'd0, 31'h7fff_ffff, 1'b1);
        send_sample(32'd0, 32'h8000_0000, 1'b0);
        send_sample(32'd1, 32'd0, 1'b0);
        send_sample(32'd2, 32'h8000_0000, 1'b1);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items,
                                     input logic [31:0] mean, input logic [30:0] threshold,
                                     input logic [30:0] domain, input bit with_long);
        int start;
        int kind;
        wait_idle();
        apply_config(mean, threshold, domain, 1'b1);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = samples_sent;
        if (with_long) send_wave_profile(MAX_SAMPLES + $urandom_range(1, 12), 1'b0);
        while (samples_sent - start < n_items) begin
            if ($urandom_range(0, 29) == 0) wait_drained();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1:    send_noise_profile($urandom_range(1, 8));
                2:       send_wave_profile($urandom_range(1, 3), 1'b0);
                3:       send_wave_profile($urandom_range(4, 16), 1'b1);
                default: send_wave_profile($urandom_range(4, 24), 1'b0);
            endcase
        end
    endtask

    task automatic report_field(input string field, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        wl_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                report_field("wavelength", 64'(want.wavelength), 64'(m_axis_tdata[30:0]));
                report_field("peak_count", 64'(want.peaks), 64'(m_axis_tdata[38:31]));
                report_field("crossing_count", 64'(want.crossings), 64'(m_axis_tdata[47:39]));
                report_field("method_used", 64'(want.method), 64'(m_axis_tuser));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_results.size());
                $display("FAIL profile_wavelength_estimator_top");
                $finish;
            end
        end
    end

    initial begin
        apply_reset();
        test_crossing_spacing();
        test_descending_x();
        test_field_extremes();
        test_invalid_profile();
        test_config_extremes();
        test_random_phase(0, 0, 300, 32'($urandom_range(0, 1 << 20) - (1 << 19)),
                          31'($urandom_range(0, 65536)), 31'($urandom), 1'b1);
        test_random_phase(71, 0, 200, 32'($urandom_range(0, 1 << 24) - (1 << 23)),
                          31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 20)),
                          1'b0);
        test_random_phase(0, 71, 200, 32'($urandom), 31'($urandom_range(0, 1024)),
                          31'($urandom), 1'b0);
        test_random_phase(13, 13, 200, 32'($urandom_range(0, 4096) - 2048),
                          31'($urandom_range(0, 1 << 12)), 31'h7fff_ffff, 1'b0);
        test_random_phase(0, 0, 60, 32'h7fff_ffff, 31'd0, 31'h7fff_ffff, 1'b0);
        test_random_phase(13, 13, 60, 32'h8000_0000, 31'h7fff_ffff, 31'd0, 1'b0);
        wait_idle();
        $display("Sent %0d samples and checked %0d results across directed profiles,",
                 samples_sent, results_checked);
        $display("several register settings and four sender/receiver idling patterns.");
        if (error_count == 0) begin
            $display("PASS profile_wavelength_estimator_top");
        end else begin
            $display("FAIL profile_wavelength_estimator_top");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/pwe_pkg.sv
rtl/pwe_div.sv
rtl/pwe_track.sv
rtl/profile_wavelength_estimator_top.sv
tb/tb.sv
